// File: rtl/tksr_pkg.sv
// ----------------------------------------------------------------------------
// tksr_pkg
// Shared types and constants of the top-k size ranker: list depth, field
// widths, function codes, register map and controller/datapath handshake.
// ----------------------------------------------------------------------------
package tksr_pkg;

	// list depth and derived widths
	localparam int MAX_RANK  = 16;
	localparam int CNT_W     = $clog2(MAX_RANK + 1);
	localparam int IDX_W     = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;

	// field widths fixed by the interface
	localparam int SIZE_W    = 32;
	localparam int TAG_W     = 16;
	localparam int RANK_W    = 4;
	localparam int LIMIT_W   = 5;
	localparam int DATA_W    = 32;
	localparam int ADDR_W    = 3;

	localparam logic [LIMIT_W-1:0] RANK_LIMIT_RESET = 5'd10;

	// register map, indexed by word address bit
	localparam logic REG_RANK_LIMIT = 1'b0;

	// function codes of an input beat
	localparam logic FUNC_OFFER = 1'b0;
	localparam logic FUNC_DUMP  = 1'b1;

	typedef enum logic {
		ST_IDLE,
		ST_DUMP
	} tksr_state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic do_offer;
		logic do_dump_start;
		logic do_emit;
	} tksr_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic slot_free;
		logic emit_last;
	} tksr_status_t;

endpackage

// File: rtl/tksr_ctrl.sv
// ----------------------------------------------------------------------------
// tksr_ctrl
// Controller of the ranker: accepts offers and dumps while idle, then
// sequences the dump beats into the output register.
// ----------------------------------------------------------------------------
module tksr_ctrl import tksr_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic         func,
	input  tksr_status_t status,
	output logic         in_stall,
	output tksr_cmd_t    cmd
);

	tksr_state_t state_q;
	tksr_state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && func == FUNC_DUMP) begin
					state_d = ST_DUMP;
				end
			end
			ST_DUMP: begin
				if (status.slot_free && status.emit_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		in_stall          = 1'b1;
		cmd.do_offer      = 1'b0;
		cmd.do_dump_start = 1'b0;
		cmd.do_emit       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall          = 1'b0;
				cmd.do_offer      = in_valid && func == FUNC_OFFER;
				cmd.do_dump_start = in_valid && func == FUNC_DUMP;
			end
			ST_DUMP: begin
				cmd.do_emit = status.slot_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

// File: rtl/tksr_datapath.sv
// ----------------------------------------------------------------------------
// tksr_datapath
// Row of size/tag cells with parallel compare-and-shift insertion, entry
// count, dump counters and the output register.
// ----------------------------------------------------------------------------
module tksr_datapath import tksr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  tksr_cmd_t          cmd,
	input  logic [LIMIT_W-1:0] rank_limit,
	input  logic [SIZE_W-1:0]  entry_size,
	input  logic [TAG_W-1:0]   entry_tag,
	input  logic               out_stall,
	output tksr_status_t       status,
	output logic               out_valid,
	output logic [RANK_W-1:0]  rank_pos,
	output logic [SIZE_W-1:0]  ranked_size,
	output logic [TAG_W-1:0]   ranked_tag,
	output logic               entry_valid,
	output logic               last_of_dump
);

	logic [SIZE_W-1:0] size_q [MAX_RANK];
	logic [TAG_W-1:0]  tag_q  [MAX_RANK];
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  rem_q;
	logic [IDX_W-1:0]  idx_q;
	logic              out_valid_q;
	logic [RANK_W-1:0] rank_pos_q;
	logic [SIZE_W-1:0] ranked_size_q;
	logic [TAG_W-1:0]  ranked_tag_q;
	logic              entry_valid_q;
	logic              last_q;

	logic [CNT_W-1:0]  lim;
	logic [CNT_W-1:0]  scan;
	logic [CNT_W-1:0]  newn;
	logic [MAX_RANK-1:0] ge;
	logic [MAX_RANK:0]   prior_hit;
	logic [MAX_RANK-1:0] wr_new;
	logic [MAX_RANK-1:0] wr_prev;
	logic              found;
	logic              room;

	// effective limit and scan window
	always_comb begin
		if (int'(rank_limit) > MAX_RANK) begin
			lim = CNT_W'(MAX_RANK);
		end else begin
			lim = CNT_W'(rank_limit);
		end
		scan = (count_q < lim) ? count_q : lim;
		room = count_q < lim;
		newn = room ? count_q + CNT_W'(1) : count_q;
	end

	// per-cell compare and first-match prefix
	always_comb begin
		prior_hit[0] = 1'b0;
		for (int i = 0; i < MAX_RANK; i++) begin
			ge[i]          = (CNT_W'(i) < scan) && (size_q[i] <= entry_size);
			prior_hit[i+1] = prior_hit[i] | ge[i];
		end
		found = prior_hit[MAX_RANK];
		for (int i = 0; i < MAX_RANK; i++) begin
			wr_new[i]  = (ge[i] && !prior_hit[i]) || (!found && room && CNT_W'(i) == count_q);
			wr_prev[i] = prior_hit[i] && (CNT_W'(i) < newn);
		end
	end

	// cell row: insert, shift down on insert, shift up on dump
	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RANK; i++) begin
			if (cmd.do_offer) begin
				if (wr_new[i]) begin
					size_q[i] <= entry_size;
					tag_q[i]  <= entry_tag;
				end else if (wr_prev[i] && i > 0) begin
					size_q[i] <= size_q[(i > 0) ? i - 1 : 0];
					tag_q[i]  <= tag_q[(i > 0) ? i - 1 : 0];
				end
			end else if (cmd.do_emit && i < MAX_RANK - 1) begin
				size_q[i] <= size_q[(i < MAX_RANK - 1) ? i + 1 : i];
				tag_q[i]  <= tag_q[(i < MAX_RANK - 1) ? i + 1 : i];
			end
		end
	end

	// entry count and dump counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rem_q   <= '0;
			idx_q   <= '0;
		end else begin
			if (cmd.do_offer && (found || room)) begin
				count_q <= newn;
			end else if (cmd.do_dump_start) begin
				count_q <= '0;
				rem_q   <= count_q;
				idx_q   <= '0;
			end else if (cmd.do_emit && rem_q != '0) begin
				rem_q <= rem_q - CNT_W'(1);
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.do_emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.do_emit) begin
			if (rem_q == '0) begin
				rank_pos_q    <= '0;
				ranked_size_q <= '0;
				ranked_tag_q  <= '0;
				entry_valid_q <= 1'b0;
				last_q        <= 1'b1;
			end else begin
				rank_pos_q    <= RANK_W'(idx_q);
				ranked_size_q <= size_q[0];
				ranked_tag_q  <= tag_q[0];
				entry_valid_q <= 1'b1;
				last_q        <= rem_q == CNT_W'(1);
			end
		end
	end

	assign status.slot_free = !out_valid_q || !out_stall;
	assign status.emit_last = rem_q <= CNT_W'(1);

	assign out_valid    = out_valid_q;
	assign rank_pos     = rank_pos_q;
	assign ranked_size  = ranked_size_q;
	assign ranked_tag   = ranked_tag_q;
	assign entry_valid  = entry_valid_q;
	assign last_of_dump = last_q;

endmodule

// File: rtl/top_k_size_ranker_core.sv
// ----------------------------------------------------------------------------
// top_k_size_ranker_core
// Keeps a descending top-k list of size/tag entries; a dump streams the list
// from largest to smallest and clears it.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------
//  in      | in_valid / in_stall  | func, entry_size, entry_tag
//  out     | out_valid / out_stall| rank_pos, ranked_size, ranked_tag,
//          |                      | entry_valid, last_of_dump
//  cfg     | apb psel/penable     | paddr, pwdata, prdata (rank_limit)
//
// on an offer all cells compare and shift in parallel, so
// offers are accepted back to back.
// a dump is accepted and then yields max(n,1) output beats, one per
// cycle while out_stall is low; input is stalled until the last beat loads.
// the output register lets an offer be accepted while a beat still waits.
// reset clears the entry count and loads rank_limit with 10; cell contents
// are not reset.
// ----------------------------------------------------------------------------
module top_k_size_ranker_core import tksr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              func,
	input  logic [SIZE_W-1:0] entry_size,
	input  logic [TAG_W-1:0]  entry_tag,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [RANK_W-1:0] rank_pos,
	output logic [SIZE_W-1:0] ranked_size,
	output logic [TAG_W-1:0]  ranked_tag,
	output logic              entry_valid,
	output logic              last_of_dump
);

	logic [LIMIT_W-1:0] rank_limit_q;
	tksr_cmd_t          cmd;
	tksr_status_t       status;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_limit_q <= RANK_LIMIT_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_RANK_LIMIT) begin
			rank_limit_q <= pwdata[LIMIT_W-1:0];
		end
	end

	// register read back
	always_comb begin
		if (paddr[2] == REG_RANK_LIMIT) begin
			prdata = DATA_W'(rank_limit_q);
		end else begin
			prdata = '0;
		end
	end

	assign pready = 1'b1;

	tksr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.func     (func),
		.status   (status),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	tksr_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.rank_limit   (rank_limit_q),
		.entry_size   (entry_size),
		.entry_tag    (entry_tag),
		.out_stall    (out_stall),
		.status       (status),
		.out_valid    (out_valid),
		.rank_pos     (rank_pos),
		.ranked_size  (ranked_size),
		.ranked_tag   (ranked_tag),
		.entry_valid  (entry_valid),
		.last_of_dump (last_of_dump)
	);

endmodule

// File: dv/tb_top_k_size_ranker_core.sv
// ----------------------------------------------------------------------------
// tb_top_k_size_ranker_core
// Self-checking bench for the top-k size ranker. Offers and dumps go in over
// the valid/stall input channel. A local model of the ranking list predicts
// every dump beat at the moment its item is accepted. Each output beat is
// checked field by field against the oldest prediction. rank_limit is
// written and read back over APB while the block is idle, and the bench steps
// it through zero, one, the list depth and values above it. Both channels
// idle at random, apart from one stretch that runs without gaps.
// ----------------------------------------------------------------------------
module tb_top_k_size_ranker_core;
	timeunit 1ns;
	timeprecision 1ps;

	import tksr_pkg::*;

	localparam int IDLE_PCT       = 36;
	localparam int SETTLE_CYCLES  = 4;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_REPORTS    = 50;
	localparam logic [ADDR_W-1:0] ADDR_RANK_LIMIT = ADDR_W'(4 * int'(REG_RANK_LIMIT));

	// one predicted output beat
	typedef struct packed {
		logic [RANK_W-1:0] idx;
		logic [SIZE_W-1:0] sz;
		logic [TAG_W-1:0]  tg;
		logic              valid;
		logic              last;
	} ranked_beat_t;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              psel         = 1'b0;
	logic              penable      = 1'b0;
	logic              pwrite       = 1'b0;
	logic [ADDR_W-1:0] paddr        = '0;
	logic [DATA_W-1:0] pwdata       = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid     = 1'b0;
	logic              in_stall;
	logic              func         = FUNC_OFFER;
	logic [SIZE_W-1:0] entry_size   = '0;
	logic [TAG_W-1:0]  entry_tag    = '0;
	logic              out_valid;
	logic              out_stall    = 1'b0;
	logic [RANK_W-1:0] rank_pos;
	logic [SIZE_W-1:0] ranked_size;
	logic [TAG_W-1:0]  ranked_tag;
	logic              entry_valid;
	logic              last_of_dump;

	// local copy of the ranking list and its limit
	logic [SIZE_W-1:0]  rk_size [MAX_RANK];
	logic [TAG_W-1:0]   rk_tag  [MAX_RANK];
	int                 rk_count;
	logic [LIMIT_W-1:0] rk_limit;

	ranked_beat_t ranked_due [$];
	int           mismatch_count = 0;
	int           quiet_cycles   = 0;
	bit           gaps_on        = 1'b1;

	top_k_size_ranker_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.entry_size   (entry_size),
		.entry_tag    (entry_tag),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.rank_pos     (rank_pos),
		.ranked_size  (ranked_size),
		.ranked_tag   (ranked_tag),
		.entry_valid  (entry_valid),
		.last_of_dump (last_of_dump)
	);

	always #5ns clk = ~clk;

	task automatic report_mismatch(input string what, input logic [SIZE_W-1:0] got,
			input logic [SIZE_W-1:0] want);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
	endtask

	// insert ahead of the first entry that is not larger, searching only up to the limit
	function automatic void rank_offer(input logic [SIZE_W-1:0] sz, input logic [TAG_W-1:0] tg);
		int lim;
		int scan;
		int pos;
		int grown;
		lim  = (int'(rk_limit) > MAX_RANK) ? MAX_RANK : int'(rk_limit);
		scan = (rk_count < lim) ? rk_count : lim;
		pos  = scan;
		for (int p = 0; p < scan; p++) begin
			if (rk_size[p] <= sz) begin
				pos = p;
				break;
			end
		end
		if (pos < scan) begin
			grown = (rk_count < lim) ? rk_count + 1 : rk_count;
			for (int i = grown - 1; i > pos; i--) begin
				rk_size[i] = rk_size[i-1];
				rk_tag[i]  = rk_tag[i-1];
			end
			rk_size[pos] = sz;
			rk_tag[pos]  = tg;
			rk_count     = grown;
		end else if (rk_count < lim) begin
			rk_size[rk_count] = sz;
			rk_tag[rk_count]  = tg;
			rk_count++;
		end
	endfunction

	// a dump streams the whole list, or one invalid beat when empty, then clears
	function automatic void rank_dump();
		ranked_beat_t b;
		if (rk_count == 0) begin
			b = '0;
			b.last = 1'b1;
			ranked_due.push_back(b);
		end
		for (int k = 0; k < rk_count; k++) begin
			b.idx   = RANK_W'(k);
			b.sz    = rk_size[k];
			b.tg    = rk_tag[k];
			b.valid = 1'b1;
			b.last  = (k + 1 == rk_count);
			ranked_due.push_back(b);
		end
		rk_count = 0;
	endfunction

	// send one item and update the prediction when it is taken
	task automatic send_beat(input logic f, input logic [SIZE_W-1:0] sz,
			input logic [TAG_W-1:0] tg);
		int gap;
		gap = 0;
		if (gaps_on)
			while ($urandom_range(0, 99) < IDLE_PCT) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		func       <= f;
		entry_size <= sz;
		entry_tag  <= tg;
		do @(posedge clk); while (in_stall);
		if (f == FUNC_OFFER)
			rank_offer(sz, tg);
		else
			rank_dump();
	endtask

	// sender holds off until every predicted beat has arrived
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (ranked_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one apb transfer; the bus is left selected for the caller to release or reuse
	task automatic apb_transfer(input logic wr, input logic [DATA_W-1:0] wdata,
			output logic [DATA_W-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= ADDR_RANK_LIMIT;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			rdata = prdata;
			@(posedge clk);
		end while (!pready);
	endtask

	task automatic read_back_limit();
		logic [DATA_W-1:0] got;
		apb_transfer(1'b0, '0, got);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (got !== DATA_W'(rk_limit))
			report_mismatch("rank_limit read back", got, DATA_W'(rk_limit));
	endtask

	task automatic set_rank_limit(input logic [LIMIT_W-1:0] value);
		logic [DATA_W-1:0] unused;
		wait_drained();
		apb_transfer(1'b1, DATA_W'(value), unused);
		rk_limit = value;
		read_back_limit();
	endtask

	// output beats against the oldest prediction
	always @(posedge clk) begin : check_beat
		ranked_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (ranked_due.size() == 0) begin
				report_mismatch("beat with nothing due, ranked_size", ranked_size, '0);
			end else begin
				want = ranked_due.pop_front();
				if (rank_pos !== want.idx)
					report_mismatch("rank_pos", SIZE_W'(rank_pos), SIZE_W'(want.idx));
				if (ranked_size !== want.sz)
					report_mismatch("ranked_size", ranked_size, want.sz);
				if (ranked_tag !== want.tg)
					report_mismatch("ranked_tag", SIZE_W'(ranked_tag), SIZE_W'(want.tg));
				if (entry_valid !== want.valid)
					report_mismatch("entry_valid", SIZE_W'(entry_valid), SIZE_W'(want.valid));
				if (last_of_dump !== want.last)
					report_mismatch("last_of_dump", SIZE_W'(last_of_dump), SIZE_W'(want.last));
			end
		end
	end

	// receiver stalls at random
	always @(posedge clk)
		out_stall <= gaps_on && ($urandom_range(0, 99) < IDLE_PCT);

	// give up when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// reset limit reads back and an empty list dumps one invalid beat
	task automatic test_reset_state();
		read_back_limit();
		send_beat(FUNC_DUMP, '1, '1);
	endtask

	// field extremes under the reset limit
	task automatic test_extremes();
		send_beat(FUNC_OFFER, '0, '0);
		send_beat(FUNC_OFFER, '1, '1);
		send_beat(FUNC_OFFER, 32'd7, 16'h5a5a);
		send_beat(FUNC_DUMP, '0, '0);
	endtask

	// equal sizes rank the newcomer first; a full list drops its tail
	task automatic test_ties_and_drops();
		set_rank_limit(5'd2);
		send_beat(FUNC_OFFER, 32'd5, 16'hffff);
		send_beat(FUNC_OFFER, 32'd5, 16'h0000);
		send_beat(FUNC_OFFER, 32'hffff_ffff, 16'h1234);
		send_beat(FUNC_OFFER, 32'd0, 16'habcd);
		send_beat(FUNC_OFFER, 32'd5, 16'h5555);
		send_beat(FUNC_DUMP, '0, '0);
	endtask

	// a zero limit ignores offers but dumps still answer
	task automatic test_zero_limit();
		set_rank_limit(5'd0);
		send_beat(FUNC_OFFER, 32'd9, 16'h0009);
		send_beat(FUNC_DUMP, '0, '0);
	endtask

	task automatic test_single_slot();
		set_rank_limit(5'd1);
		send_beat(FUNC_OFFER, 32'd3, 16'h0003);
		send_beat(FUNC_OFFER, 32'd9, 16'h0009);
		send_beat(FUNC_OFFER, 32'd1, 16'h0001);
		send_beat(FUNC_OFFER, 32'd9, 16'h0099);
		send_beat(FUNC_DUMP, '0, '0);
	endtask

	// limit lowered under the stored count: search is cut short, dump shows all
	task automatic test_lowered_limit();
		set_rank_limit(5'd4);
		send_beat(FUNC_OFFER, 32'd10, 16'h0010);
		send_beat(FUNC_OFFER, 32'd8, 16'h0008);
		send_beat(FUNC_OFFER, 32'd6, 16'h0006);
		send_beat(FUNC_OFFER, 32'd4, 16'h0004);
		set_rank_limit(5'd2);
		send_beat(FUNC_OFFER, 32'd7, 16'h0007);
		send_beat(FUNC_OFFER, 32'd9, 16'h0009);
		send_beat(FUNC_DUMP, '0, '0);
	endtask

	// sender waits mid-stream for the dump to finish
	task automatic test_pause_until_drained();
		set_rank_limit(5'd16);
		repeat (3) send_beat(FUNC_OFFER, $urandom, 16'($urandom));
		send_beat(FUNC_DUMP, '0, '0);
		wait_drained();
		repeat (2) send_beat(FUNC_OFFER, $urandom, 16'($urandom));
		send_beat(FUNC_DUMP, '0, '0);
	endtask

	// random offers and dumps over a range of limits
	task automatic test_random_phases();
		int unsigned limits   [9];
		int unsigned items    [9];
		int unsigned dump_pct [9];
		logic [SIZE_W-1:0] sz;
		limits   = '{16, 31, 1, 17, 0, 6, 12, 16, 3};
		items    = '{60, 60, 30, 50, 16, 40, 60, 60, 40};
		dump_pct = '{5, 4, 20, 5, 30, 12, 8, 6, 15};
		limits[8] = $urandom_range(2, 15);
		for (int ph = 0; ph < 9; ph++) begin
			// one phase with no idling on either side
			gaps_on = (ph != 6);
			set_rank_limit(LIMIT_W'(limits[ph]));
			for (int n = 0; n < items[ph]; n++) begin
				if ($urandom_range(0, 99) < dump_pct[ph]) begin
					send_beat(FUNC_DUMP, $urandom, 16'($urandom));
				end else begin
					case ($urandom_range(0, 9))
						0: begin
							sz = '0;
						end
						1: begin
							sz = '1;
						end
						2, 3, 4: begin
							sz = $urandom_range(0, 7);
						end
						default: begin
							sz = $urandom;
						end
					endcase
					send_beat(FUNC_OFFER, sz, 16'($urandom_range(0, 65535)));
				end
				if ($urandom_range(0, 59) == 0)
					wait_drained();
			end
		end
		gaps_on = 1'b1;
		send_beat(FUNC_DUMP, '0, '0);
	endtask

	initial begin
		for (int i = 0; i < MAX_RANK; i++) begin
			rk_size[i] = '0;
			rk_tag[i]  = '0;
		end
		rk_count = 0;
		rk_limit = RANK_LIMIT_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_extremes();
		test_ties_and_drops();
		test_zero_limit();
		test_single_slot();
		test_lowered_limit();
		test_pause_until_drained();
		test_random_phases();

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// File: sim.f
rtl/tksr_pkg.sv
rtl/tksr_ctrl.sv
rtl/tksr_datapath.sv
rtl/top_k_size_ranker_core.sv
dv/tb_top_k_size_ranker_core.sv
